// ===== sv/tgarle_pkg.sv =====
// shared types, constants and position helpers for the tga rle pixel unpacker
`default_nettype none
package tgarle_pkg;

  localparam int MAX_DIM     = 4096;
  localparam int DIM_W       = 13;
  localparam int COL_W       = 12;
  localparam int ADDR_W      = 24;
  localparam int PIX_W       = 32;
  localparam int CNT_W       = 8;
  localparam int TOTAL_W     = 25;
  localparam int BPP_W       = 3;
  localparam int MAX_BPP     = 4;
  localparam int SLOT_W      = 2;
  localparam int BYTE_W      = 8;
  localparam int IDX_W       = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

  typedef logic [IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_IMAGE_WIDTH     = 3'd0;
  localparam cfg_idx_t REG_IMAGE_HEIGHT    = 3'd1;
  localparam cfg_idx_t REG_BYTES_PER_PIXEL = 3'd2;
  localparam cfg_idx_t REG_MIRROR_X        = 3'd3;
  localparam cfg_idx_t REG_MIRROR_Y        = 3'd4;
  localparam cfg_idx_t REG_RLE_ENABLED     = 3'd5;

  typedef enum logic {
    PH_HEADER,
    PH_DATA
  } phase_t;

  // effective (clamped) configuration
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [BPP_W-1:0] bpp;
    logic             mirror_x;
    logic             mirror_y;
    logic             rle;
  } cfg_t;

  // one pixel value and the number of positions it fills
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [CNT_W-1:0] count;
  } cmd_t;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ADDR_W-1:0] row_base;
    logic [DIM_W-1:0]  rows_left;
  } pos_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [BPP_W-1:0] eff_bpp(input logic [BPP_W-1:0] v);
    logic [BPP_W-1:0] r;
    if (v == '0) begin
      r = BPP_W'(1);
    end else if (v > BPP_W'(MAX_BPP)) begin
      r = BPP_W'(MAX_BPP);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] pos_addr(input pos_t p);
    return p.row_base + ADDR_W'(p.col);
  endfunction

  function automatic pos_t pos_next(input pos_t p, input cfg_t c);
    pos_t             n;
    logic             wrap;
    logic [DIM_W-1:0] rl_dec;
    n = p;
    if (c.mirror_x) begin
      wrap  = (p.col == '0);
      n.col = wrap ? COL_W'(c.width - DIM_W'(1)) : p.col - COL_W'(1);
    end else begin
      wrap  = (({1'b0, p.col} + DIM_W'(1)) >= c.width);
      n.col = wrap ? '0 : p.col + COL_W'(1);
    end
    rl_dec = p.rows_left - DIM_W'(1);
    if (wrap && (p.rows_left != '0)) begin
      n.rows_left = rl_dec;
      if (rl_dec != '0) begin
        n.row_base = c.mirror_y ? p.row_base - ADDR_W'(c.width)
                                : p.row_base + ADDR_W'(c.width);
      end
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== sv/tgarle_front.sv =====
// front end: packet header parsing, pixel byte assembly and image-end clamping
`default_nettype none
module tgarle_front (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     restart,
  input  tgarle_pkg::cfg_t        cfg,
  input  wire [tgarle_pkg::TOTAL_W-1:0] total_pixels,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire [7:0]               in_data_byte,
  input  wire                     q_full,
  output logic                    q_push,
  output tgarle_pkg::cmd_t        q_cmd
);
  import tgarle_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   remaining_r, remaining_nxt;
  logic               is_run_r, is_run_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [PIX_W-1:0]   accum_r, accum_nxt;
  logic [TOTAL_W-1:0] pixels_left_r, pixels_left_nxt;

  logic               take;
  logic               is_header;
  logic               pix_done;
  logic [PIX_W-1:0]   merged;
  logic [CNT_W-1:0]   run_count;
  logic [CNT_W-1:0]   push_count;

  assign in_ready  = !restart && !q_full;
  assign take      = in_valid && in_ready && (pixels_left_r != '0);
  assign is_header = cfg.rle && (phase_r == PH_HEADER);
  assign merged    = accum_r | (PIX_W'(in_data_byte) << {slot_r, 3'b000});
  assign pix_done  = !is_header && !(({1'b0, slot_r} + BPP_W'(1)) < cfg.bpp);
  assign run_count = (pixels_left_r < TOTAL_W'(remaining_r)) ?
                     pixels_left_r[CNT_W-1:0] : remaining_r;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (take) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (cfg.rle) begin
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          if (pix_done && cfg.rle && (is_run_r || (remaining_r <= CNT_W'(1)))) begin
            phase_nxt = PH_HEADER;
          end
        end
        default: phase_nxt = PH_HEADER;
      endcase
    end
  end

  // datapath and queue outputs
  always_comb begin
    remaining_nxt   = remaining_r;
    is_run_nxt      = is_run_r;
    slot_nxt        = slot_r;
    accum_nxt       = accum_r;
    pixels_left_nxt = pixels_left_r;
    push_count      = CNT_W'(1);
    q_push          = 1'b0;
    if (cfg.rle && is_run_r) begin
      push_count = run_count;
    end
    if (take) begin
      if (is_header) begin
        remaining_nxt = CNT_W'(in_data_byte[6:0]) + CNT_W'(1);
        is_run_nxt    = in_data_byte[7];
        slot_nxt      = '0;
        accum_nxt     = '0;
      end else if (!pix_done) begin
        slot_nxt  = slot_r + SLOT_W'(1);
        accum_nxt = merged;
      end else begin
        slot_nxt        = '0;
        accum_nxt       = '0;
        q_push          = 1'b1;
        pixels_left_nxt = pixels_left_r - TOTAL_W'(push_count);
        if (cfg.rle) begin
          if (is_run_r) begin
            remaining_nxt = '0;
          end else if (remaining_r != '0) begin
            remaining_nxt = remaining_r - CNT_W'(1);
          end
        end
      end
    end
  end

  assign q_cmd.pixel = merged;
  assign q_cmd.count = push_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HEADER;
      remaining_r   <= '0;
      is_run_r      <= 1'b0;
      slot_r        <= '0;
      accum_r       <= '0;
      pixels_left_r <= '0;
    end else if (restart) begin
      phase_r       <= PH_HEADER;
      remaining_r   <= '0;
      is_run_r      <= 1'b0;
      slot_r        <= '0;
      accum_r       <= '0;
      pixels_left_r <= total_pixels;
    end else begin
      phase_r       <= phase_nxt;
      remaining_r   <= remaining_nxt;
      is_run_r      <= is_run_nxt;
      slot_r        <= slot_nxt;
      accum_r       <= accum_nxt;
      pixels_left_r <= pixels_left_nxt;
    end
  end

  a_data_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (remaining_r != '0))
    else $error("front in data phase with no pixels left in packet");

  a_push_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> ((q_cmd.count != '0) && (TOTAL_W'(q_cmd.count) <= pixels_left_r)))
    else $error("front pushed a count beyond the image end");

endmodule
`default_nettype wire

// ===== sv/tgarle_fifo.sv =====
// short command queue between front and back
`default_nettype none
module tgarle_fifo (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               clear,
  input  wire               push,
  input  tgarle_pkg::cmd_t  push_cmd,
  output logic              full,
  input  wire               pop,
  output logic              valid,
  output tgarle_pkg::cmd_t  head
);
  import tgarle_pkg::*;

  cmd_t                   entry_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r;
  logic [QUEUE_CNT_W-1:0] count_r;
  logic                   do_push;
  logic                   do_pop;

  assign full    = (count_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign valid   = (count_r != '0);
  assign head    = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QUEUE_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("command pushed into full queue");

endmodule
`default_nettype wire

// ===== sv/tgarle_back.sv =====
// back end: walks image positions and emits pixel results
`default_nettype none
module tgarle_back (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          restart,
  input  tgarle_pkg::cfg_t             cfg,
  input  wire [tgarle_pkg::ADDR_W-1:0] row_base_start,
  input  wire                          q_valid,
  input  tgarle_pkg::cmd_t             q_head,
  output logic                         q_pop,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [31:0]                  out_pixel_bytes,
  output logic [23:0]                  out_first_address,
  output logic [23:0]                  out_second_address,
  output logic                         out_second_valid,
  output logic                         out_image_done,
  output logic                         out_last_of_run
);
  import tgarle_pkg::*;

  logic             cur_valid_r;
  logic [CNT_W-1:0] cur_cnt_r;
  logic [PIX_W-1:0] cur_pix_r;
  pos_t             pos_r;
  logic             out_valid_r;

  logic             step;
  logic             two;
  logic             last;
  pos_t             p1;
  pos_t             p2;
  pos_t             pos_nxt;

  assign step    = cur_valid_r && (!out_valid_r || out_ready);
  assign two     = (cur_cnt_r >= CNT_W'(2));
  assign last    = (cur_cnt_r <= CNT_W'(2));
  assign p1      = pos_next(pos_r, cfg);
  assign p2      = pos_next(p1, cfg);
  assign pos_nxt = two ? p2 : p1;
  assign q_pop   = q_valid && (!cur_valid_r || (step && last));
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid_r <= 1'b1;
      end else if (step && last) begin
        cur_valid_r <= 1'b0;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r.col       <= '0;
      pos_r.row_base  <= '0;
      pos_r.rows_left <= DIM_W'(1);
    end else if (restart) begin
      pos_r.col       <= cfg.mirror_x ? COL_W'(cfg.width - DIM_W'(1)) : '0;
      pos_r.row_base  <= cfg.mirror_y ? row_base_start : '0;
      pos_r.rows_left <= cfg.height;
    end else if (step) begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_cnt_r <= q_head.count;
      cur_pix_r <= q_head.pixel;
    end else if (step) begin
      cur_cnt_r <= cur_cnt_r - (two ? CNT_W'(2) : CNT_W'(1));
    end
    if (step) begin
      out_pixel_bytes    <= cur_pix_r;
      out_first_address  <= pos_addr(pos_r);
      out_second_address <= two ? pos_addr(p1) : '0;
      out_second_valid   <= two;
      out_image_done     <= (pos_nxt.rows_left == '0);
      out_last_of_run    <= last;
    end
  end

  a_cur_count: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (cur_cnt_r != '0))
    else $error("active command with zero count");

  a_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_second_valid) |-> (out_second_address == '0))
    else $error("second address set without second pixel");

endmodule
`default_nettype wire

// ===== sv/tga_rle_pixel_unpacker_top.sv =====
// top level: configuration registers, restart control, front, queue and back
// a pixel passes the queue, the back's command registers and its output registers
// one byte per cycle while the queue has room; an n-pixel run gives ceil(n/2) results
// the back loads a new command in the cycle its previous one finishes
// reset and writes to defined registers restart the image; no byte is taken during it
`default_nettype none
module tga_rle_pixel_unpacker_top (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [2:0]  cfg_index,
  input  wire  [12:0] cfg_data,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  in_data_byte,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] out_pixel_bytes,
  output logic [23:0] out_first_address,
  output logic [23:0] out_second_address,
  output logic        out_second_valid,
  output logic        out_image_done,
  output logic        out_last_of_run
);
  import tgarle_pkg::*;

  logic [DIM_W-1:0]   width_r;
  logic [DIM_W-1:0]   height_r;
  logic [BPP_W-1:0]   bpp_r;
  logic               mirror_x_r;
  logic               mirror_y_r;
  logic               rle_r;
  logic               pending_r;
  logic               cfg_hit;
  cfg_t               cfg;
  logic [TOTAL_W-1:0] area;
  logic [ADDR_W-1:0]  last_row_prod;
  logic               q_full;
  logic               q_push;
  cmd_t               push_cmd;
  logic               q_valid;
  logic               q_pop;
  cmd_t               q_head;

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && cfg_ready &&
                     ((cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT) ||
                      (cfg_index == REG_BYTES_PER_PIXEL) || (cfg_index == REG_MIRROR_X) ||
                      (cfg_index == REG_MIRROR_Y) || (cfg_index == REG_RLE_ENABLED));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= DIM_W'(1);
      height_r   <= DIM_W'(1);
      bpp_r      <= BPP_W'(4);
      mirror_x_r <= 1'b0;
      mirror_y_r <= 1'b0;
      rle_r      <= 1'b1;
      pending_r  <= 1'b1;
    end else begin
      pending_r <= cfg_hit;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH:     width_r    <= cfg_data[DIM_W-1:0];
          REG_IMAGE_HEIGHT:    height_r   <= cfg_data[DIM_W-1:0];
          REG_BYTES_PER_PIXEL: bpp_r      <= cfg_data[BPP_W-1:0];
          REG_MIRROR_X:        mirror_x_r <= cfg_data[0];
          REG_MIRROR_Y:        mirror_y_r <= cfg_data[0];
          REG_RLE_ENABLED:     rle_r      <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  assign cfg.width    = eff_dim(width_r);
  assign cfg.height   = eff_dim(height_r);
  assign cfg.bpp      = eff_bpp(bpp_r);
  assign cfg.mirror_x = mirror_x_r;
  assign cfg.mirror_y = mirror_y_r;
  assign cfg.rle      = rle_r;

  assign area          = TOTAL_W'(cfg.width) * TOTAL_W'(cfg.height);
  assign last_row_prod = ADDR_W'(cfg.height - DIM_W'(1)) * ADDR_W'(cfg.width);

  tgarle_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .restart      (pending_r),
    .cfg          (cfg),
    .total_pixels (area),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  tgarle_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (pending_r),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  tgarle_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .restart            (pending_r),
    .cfg                (cfg),
    .row_base_start     (last_row_prod),
    .q_valid            (q_valid),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_pixel_bytes    (out_pixel_bytes),
    .out_first_address  (out_first_address),
    .out_second_address (out_second_address),
    .out_second_valid   (out_second_valid),
    .out_image_done     (out_image_done),
    .out_last_of_run    (out_last_of_run)
  );

endmodule
`default_nettype wire
